[rtl/core/midi_track_event_parser_unit_defines.svh]
// Assertion macros used by the track event parser top level.
// Depends on a clock named clk and a reset named rst in the asserting scope.
`ifndef MIDI_TRACK_EVENT_PARSER_UNIT_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MTEP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("parser check failed");

// Next-cycle implication, checked outside reset.
`define MTEP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("parser check failed");

`endif

[rtl/core/mtep_pkg.sv]
// Shared types and constants of the track event parser.
// No dependencies.
package mtep_pkg;

  localparam logic [2:0] KIND_CHAN  = 3'd0;
  localparam logic [2:0] KIND_MHEAD = 3'd1;
  localparam logic [2:0] KIND_MDATA = 3'd2;
  localparam logic [2:0] KIND_EOT   = 3'd3;
  localparam logic [2:0] KIND_PREM  = 3'd4;

  localparam logic [2:0] CFG_TIMING_IS_FPS     = 3'd0;
  localparam logic [2:0] CFG_FRAMES_PER_SECOND = 3'd1;
  localparam logic [2:0] CFG_FRAME_TICKS       = 3'd2;
  localparam logic [2:0] CFG_BEAT_TICKS        = 3'd3;
  localparam logic [2:0] CFG_TEMPO_US          = 3'd4;

  localparam logic [19:0] US_PER_SECOND = 20'd1000000;

  // One classified result waiting for its delay to be attached.
  typedef struct packed {
    logic [2:0]  kind;
    logic        use_delay;
    logic [27:0] ticks;
    logic [3:0]  event_type;
    logic [3:0]  channel;
    logic [6:0]  first_param;
    logic [6:0]  second_param;
    logic [7:0]  meta_type;
    logic [27:0] meta_length;
    logic [7:0]  data_byte;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic        timing_is_fps;
    logic [6:0]  frames_per_second;
    logic [7:0]  frame_ticks;
    logic [14:0] beat_ticks;
    logic [23:0] tempo_us;
  } cfg_t;

endpackage

[rtl/core/mtep_front.sv]
// Byte-level parser: walks delta times, status, data and meta fields.
// Depends on mtep_pkg; pushes classified results into the queue.
module mtep_front #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic               func,
  input  logic [7:0]         track_byte,
  output logic               push,
  output mtep_pkg::rec_t     rec
);

  typedef enum logic [2:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_MTYPE, PH_MLEN, PH_MDATA
  } phase_t;

  phase_t      phase;
  logic [27:0] acc;
  logic [2:0]  cnt;
  logic [27:0] ticks;
  logic [3:0]  running_type;
  logic [3:0]  running_channel;
  logic [6:0]  held_first;
  logic [7:0]  held_meta_type;
  logic [27:0] meta_rem;
  logic        ended;
  logic [3:0]  meta_channel;

  logic [27:0] acc_next;
  logic [2:0]  cnt_next;
  logic        len_done;
  logic [27:0] rem_next;
  logic        one_byte;
  logic        is_eot;

  assign acc_next = {acc[20:0], track_byte[6:0]};
  assign cnt_next = cnt + 3'd1;
  assign len_done = !track_byte[7] || (cnt_next >= 3'(MAX_LENGTH_BYTES));
  assign rem_next = meta_rem - 28'd1;
  assign one_byte = (running_type == 4'hC) || (running_type == 4'hD);
  assign is_eot   = (held_meta_type == 8'h2F);

  always_comb begin
    rec  = '0;
    push = 1'b0;
    if (ended) begin
      push     = 1'b1;
      rec.kind = mtep_pkg::KIND_EOT;
      rec.last = 1'b1;
    end else if (func) begin
      push     = 1'b1;
      rec.kind = mtep_pkg::KIND_PREM;
      rec.last = 1'b1;
    end else begin
      rec.use_delay = 1'b1;
      rec.ticks     = ticks;
      case (phase)
        PH_STATUS, PH_DATA1, PH_DATA2: begin
          rec.kind        = mtep_pkg::KIND_CHAN;
          rec.event_type  = running_type;
          rec.channel     = running_channel;
          rec.last        = 1'b1;
          if (phase == PH_DATA2) begin
            push             = 1'b1;
            rec.first_param  = held_first;
            rec.second_param = track_byte[6:0];
          end else begin
            push            = one_byte && !(phase == PH_STATUS && track_byte[7]);
            rec.first_param = track_byte[6:0];
          end
        end
        PH_MLEN: begin
          push           = len_done;
          rec.event_type = 4'hF;
          rec.channel    = meta_channel;
          rec.meta_type  = held_meta_type;
          rec.meta_length = acc_next;
          if (acc_next == 28'd0) begin
            rec.kind = is_eot ? mtep_pkg::KIND_EOT : mtep_pkg::KIND_MHEAD;
            rec.last = 1'b1;
          end else begin
            rec.kind = mtep_pkg::KIND_MHEAD;
          end
        end
        PH_MDATA: begin
          push            = 1'b1;
          rec.event_type  = 4'hF;
          rec.channel     = meta_channel;
          rec.meta_type   = held_meta_type;
          rec.meta_length = acc;
          rec.data_byte   = track_byte;
          rec.last        = (rem_next == 28'd0);
          rec.kind        = (rem_next == 28'd0 && is_eot) ? mtep_pkg::KIND_EOT
                                                           : mtep_pkg::KIND_MDATA;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_DELTA;
      acc             <= '0;
      cnt             <= '0;
      ticks           <= '0;
      running_type    <= '0;
      running_channel <= '0;
      held_first      <= '0;
      held_meta_type  <= '0;
      meta_rem        <= '0;
      ended           <= 1'b0;
      meta_channel    <= '0;
    end else if (fire && !ended) begin
      if (func) begin
        phase    <= PH_DELTA;
        acc      <= '0;
        cnt      <= '0;
        meta_rem <= '0;
      end else begin
        case (phase)
          PH_STATUS, PH_DATA1: begin
            if (phase == PH_STATUS && track_byte[7]) begin
              if (track_byte[7:4] == 4'hF) begin
                meta_channel <= track_byte[3:0];
                phase        <= PH_MTYPE;
              end else begin
                running_type    <= track_byte[7:4];
                running_channel <= track_byte[3:0];
                phase           <= PH_DATA1;
              end
            end else begin
              held_first <= track_byte[6:0];
              if (one_byte) begin
                phase <= PH_DELTA;
                acc   <= '0;
                cnt   <= '0;
              end else begin
                phase <= PH_DATA2;
              end
            end
          end
          PH_DATA2: begin
            phase <= PH_DELTA;
            acc   <= '0;
            cnt   <= '0;
          end
          PH_MTYPE: begin
            held_meta_type <= track_byte;
            acc            <= '0;
            cnt            <= '0;
            phase          <= PH_MLEN;
          end
          PH_MLEN: begin
            acc <= acc_next;
            cnt <= cnt_next;
            if (len_done) begin
              meta_rem <= acc_next;
              if (acc_next == 28'd0) begin
                if (is_eot) begin
                  ended <= 1'b1;
                end
                phase <= PH_DELTA;
                acc   <= '0;
                cnt   <= '0;
              end else begin
                phase <= PH_MDATA;
              end
            end
          end
          PH_MDATA: begin
            meta_rem <= rem_next;
            if (rem_next == 28'd0) begin
              if (is_eot) begin
                ended <= 1'b1;
              end
              phase <= PH_DELTA;
              acc   <= '0;
              cnt   <= '0;
            end
          end
          default: begin
            acc <= acc_next;
            cnt <= cnt_next;
            if (len_done) begin
              ticks <= acc_next;
              acc   <= '0;
              cnt   <= '0;
              phase <= PH_STATUS;
            end
          end
        endcase
      end
    end
  end

endmodule

[rtl/core/mtep_queue.sv]
// Two-entry queue of classified results between the parser and the back end.
// Depends on mtep_pkg for the entry type.
module mtep_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mtep_pkg::rec_t wr_rec,
  input  logic           pop,
  output mtep_pkg::rec_t rd_rec,
  output logic           empty,
  output logic           full
);

  mtep_pkg::rec_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign empty  = (count == 2'd0);
  assign full   = (count == 2'd2);
  assign rd_rec = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

[rtl/core/mtep_back.sv]
// Back end: converts ticks to microseconds and drives the result register.
// Depends on mtep_pkg; one multiply stage, then a radix-2 divider at 4 bits a cycle.
module mtep_back (
  input  logic           clk,
  input  logic           rst,
  input  mtep_pkg::cfg_t cfg,
  input  logic           cfg_wr,
  input  logic           q_empty,
  input  mtep_pkg::rec_t q_rec,
  output logic           pop,
  input  logic           out_stall,
  output logic           out_valid,
  output mtep_pkg::rec_t out_rec,
  output logic [59:0]    out_delay
);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_EMIT} state_t;

  state_t         state;
  mtep_pkg::rec_t work;
  logic           cache_ok;
  logic [27:0]    cache_ticks;
  logic [59:0]    cache_delay;
  logic [59:0]    dq;
  logic [15:0]    rem;
  logic [14:0]    den;
  logic [3:0]     steps;

  logic [23:0]    mult;
  logic [14:0]    den_sel;
  logic [51:0]    prod;
  logic [59:0]    dq_next;
  logic [15:0]    rem_next;
  logic [15:0]    r;
  logic           need;
  logic           cache_set;
  logic           emit_now;

  assign pop     = (state == ST_IDLE) && !q_empty;
  assign need    = q_rec.use_delay && (!cache_ok || q_rec.ticks != cache_ticks);
  assign mult    = cfg.timing_is_fps ? 24'(mtep_pkg::US_PER_SECOND) : cfg.tempo_us;
  assign den_sel = cfg.timing_is_fps ? 15'(cfg.frames_per_second) * 15'(cfg.frame_ticks)
                                     : cfg.beat_ticks;
  assign prod    = work.ticks * mult;

  // The cached delay becomes valid when a conversion finishes.
  assign cache_set = ((state == ST_MUL) && (den_sel == 15'd0)) ||
                     ((state == ST_DIV) && (steps == 4'd14));
  assign emit_now  = (state == ST_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    dq_next  = dq;
    rem_next = rem;
    r        = '0;
    for (int i = 0; i < 4; i++) begin
      r       = {rem_next[14:0], dq_next[59]};
      dq_next = {dq_next[58:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r          = r - {1'b0, den};
        dq_next[0] = 1'b1;
      end
      rem_next = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cache_ok  <= 1'b0;
      out_valid <= 1'b0;
      steps     <= '0;
    end else begin
      if (cfg_wr) begin
        cache_ok <= 1'b0;
      end else if (cache_set) begin
        cache_ok <= 1'b1;
      end
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            work  <= q_rec;
            state <= need ? ST_MUL : ST_EMIT;
          end
        end
        ST_MUL: begin
          cache_ticks <= work.ticks;
          if (den_sel == 15'd0) begin
            cache_delay <= '1;
            state       <= ST_EMIT;
          end else begin
            dq    <= {prod, 8'd0};
            rem   <= '0;
            den   <= den_sel;
            steps <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          dq    <= dq_next;
          rem   <= rem_next;
          steps <= steps + 4'd1;
          if (steps == 4'd14) begin
            cache_delay <= dq_next;
            state       <= ST_EMIT;
          end
        end
        default: begin
          if (emit_now) begin
            out_rec   <= work;
            out_delay <= work.use_delay ? cache_delay : '0;
            state     <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

[rtl/core/midi_track_event_parser_unit.sv]
// Track event parser of a standard MIDI file, fed one track byte per item.
// The input channel (in_valid, in_stall) carries func and track_byte; a func of
// one marks end of input. The output channel (out_valid, out_stall) carries one
// decoded result per item: channel events, meta headers, meta data bytes, end of
// track and premature end. Configuration registers are written through cfg_valid,
// cfg_index and cfg_data; cfg_ready is always high. Writes are to be made only while
// the block is idle; the block itself does not enforce this.
// A byte that yields no result only advances the parser. A result whose delay
// is already known passes from its queue slot to the back end's work register and
// then to the output register; the back end takes no new result until it has emitted.
// A result whose delta time differs from the last one converted, or the first after
// a configuration write, also runs the tick-to-microsecond conversion: a multiply
// step, then the divider (four quotient bits per cycle), shared by every result
// of that event.
// A two-entry queue separates parser and back end, so the parser keeps taking
// bytes while a result waits; in_stall rises only when that queue is full.
// When the receiver stalls, the result register holds its item unchanged.
// Synchronous reset restores the configuration defaults and puts the parser at
// the start of a delta time with the queue and output empty.
// Depends on mtep_pkg, mtep_front, mtep_queue, mtep_back and midi_track_event_parser_unit_defines.svh.
`include "midi_track_event_parser_unit_defines.svh"

module midi_track_event_parser_unit #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  track_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [59:0] delay_us_q8,
  output logic [3:0]  event_type,
  output logic [3:0]  channel,
  output logic [6:0]  first_param,
  output logic [6:0]  second_param,
  output logic [7:0]  meta_type,
  output logic [27:0] meta_length,
  output logic [7:0]  data_byte,
  output logic        last
);

  mtep_pkg::cfg_t cfg;
  mtep_pkg::rec_t front_rec;
  mtep_pkg::rec_t q_rec;
  mtep_pkg::rec_t out_rec;
  logic           front_push;
  logic           q_empty;
  logic           q_full;
  logic           q_pop;
  logic           in_fire;
  logic           cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = q_full;
  assign in_fire   = in_valid && !in_stall;

  // Configuration registers; indexes outside the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timing_is_fps     <= 1'b0;
      cfg.frames_per_second <= 7'd25;
      cfg.frame_ticks       <= 8'd40;
      cfg.beat_ticks        <= 15'd96;
      cfg.tempo_us          <= 24'd500000;
    end else if (cfg_wr) begin
      case (cfg_index)
        mtep_pkg::CFG_TIMING_IS_FPS:     cfg.timing_is_fps     <= cfg_data[0];
        mtep_pkg::CFG_FRAMES_PER_SECOND: cfg.frames_per_second <= cfg_data[6:0];
        mtep_pkg::CFG_FRAME_TICKS:       cfg.frame_ticks       <= cfg_data[7:0];
        mtep_pkg::CFG_BEAT_TICKS:        cfg.beat_ticks        <= cfg_data[14:0];
        mtep_pkg::CFG_TEMPO_US:          cfg.tempo_us          <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mtep_front #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .fire       (in_fire),
    .func       (func),
    .track_byte (track_byte),
    .push       (front_push),
    .rec        (front_rec)
  );

  mtep_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (in_fire && front_push),
    .wr_rec (front_rec),
    .pop    (q_pop),
    .rd_rec (q_rec),
    .empty  (q_empty),
    .full   (q_full)
  );

  mtep_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_wr    (cfg_wr),
    .q_empty   (q_empty),
    .q_rec     (q_rec),
    .pop       (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_rec   (out_rec),
    .out_delay (delay_us_q8)
  );

  assign kind         = out_rec.kind;
  assign event_type   = out_rec.event_type;
  assign channel      = out_rec.channel;
  assign first_param  = out_rec.first_param;
  assign second_param = out_rec.second_param;
  assign meta_type    = out_rec.meta_type;
  assign meta_length  = out_rec.meta_length;
  assign data_byte    = out_rec.data_byte;
  assign last         = out_rec.last;

  // A premature end belongs to no event, so it carries no delay and closes.
  `MTEP_ASSERT_NOW(a_prem_clean, out_valid && kind == mtep_pkg::KIND_PREM,
    last && delay_us_q8 == 60'd0)
  // Channel events are always complete in one result.
  `MTEP_ASSERT_NOW(a_chan_last, out_valid && kind == mtep_pkg::KIND_CHAN, last)
  // Meta data results always carry the meta status nibble.
  `MTEP_ASSERT_NOW(a_mdata_type, out_valid && kind == mtep_pkg::KIND_MDATA,
    event_type == 4'hF)
  // The back end never takes from an empty queue.
  `MTEP_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty)

endmodule

[tb/midi_track_event_parser_unit_test.sv]
// Self-checking testbench of the MIDI track event parser unit.
// Depends on mtep_pkg and the midi_track_event_parser_unit RTL.
module midi_track_event_parser_unit_test;

  // One decoded result, with the fields in port order.
  typedef struct packed {
    logic [2:0]  kind;
    logic [59:0] delay_us_q8;
    logic [3:0]  event_type;
    logic [3:0]  channel;
    logic [6:0]  first_param;
    logic [6:0]  second_param;
    logic [7:0]  meta_type;
    logic [27:0] meta_length;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

  // Parser phases of the local copy of the block.
  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_MTYPE, PH_MLEN, PH_MDATA
  } phase_t;

  // One row of the directed table; a typed row also names the kind it must give.
  typedef struct packed {
    logic       f;
    logic [7:0] b;
    logic       typed;
    logic [2:0] k;
  } dir_row_t;

  localparam int NUM_ITEMS = 1450;
  localparam int MAX_LEN_BYTES = 4;
  localparam int IDLE_PCT = 32;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int CFG_PERIOD = 200;
  localparam logic [7:0] META_EOT = 8'h2F;
  localparam logic [59:0] DELAY_SAT = {60{1'b1}};
  localparam int DIR_ROWS = 30;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        func;
  logic [7:0]  track_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  kind;
  logic [59:0] delay_us_q8;
  logic [3:0]  event_type;
  logic [3:0]  channel;
  logic [6:0]  first_param;
  logic [6:0]  second_param;
  logic [7:0]  meta_type;
  logic [27:0] meta_length;
  logic [7:0]  data_byte;
  logic        last;

  midi_track_event_parser_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .track_byte(track_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .delay_us_q8(delay_us_q8), .event_type(event_type), .channel(channel),
    .first_param(first_param), .second_param(second_param), .meta_type(meta_type),
    .meta_length(meta_length), .data_byte(data_byte), .last(last)
  );

  // Results the parser owes us, oldest first.
  result_t pending_results[$];

  int  error_count = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  config_sets = 0;
  int  quiet_cycles = 0;
  // While calm is set neither side idles, which gives back-to-back traffic.
  bit  calm = 0;

  // Local copy of the configuration registers.
  logic        cur_fps_mode;
  logic [6:0]  cur_fps;
  logic [7:0]  cur_tpf;
  logic [14:0] cur_tpb;
  logic [23:0] cur_mpb;

  // Local copy of the parser state.
  phase_t      pr_phase;
  logic [27:0] pr_len_acc;
  logic [2:0]  pr_len_cnt;
  logic [27:0] pr_ticks;
  logic [3:0]  pr_run_type;
  logic [3:0]  pr_run_chan;
  logic [6:0]  pr_first;
  logic [7:0]  pr_meta_type;
  logic [27:0] pr_meta_left;
  logic        pr_ended;
  logic [3:0]  pr_meta_chan;

  // The clock has a period of 12 time units.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Delta time of the held event, scaled to microseconds in Q.8 and truncated.
  // A zero divisor saturates the result.
  function automatic logic [59:0] scaled_delay();
    logic [63:0] num;
    logic [63:0] den;
    if (cur_fps_mode) begin
      num = 64'(pr_ticks) * 64'd256000000;
      den = 64'(cur_fps) * 64'(cur_tpf);
    end else begin
      num = 64'(pr_ticks) * 64'(cur_mpb) * 64'd256;
      den = 64'(cur_tpb);
    end
    if (den == 64'd0) return DELAY_SAT;
    return 60'(num / den);
  endfunction

  // Adds one variable-length byte and reports whether the field is complete.
  // The field also ends after the maximum byte count, whatever the top bit says.
  function automatic bit take_length_byte(input logic [7:0] b);
    pr_len_acc = {pr_len_acc[20:0], b[6:0]};
    pr_len_cnt = pr_len_cnt + 3'd1;
    return !b[7] || (pr_len_cnt >= MAX_LEN_BYTES);
  endfunction

  function automatic result_t channel_result(input logic [6:0] second);
    result_t r;
    r = '0;
    r.kind = mtep_pkg::KIND_CHAN;
    r.delay_us_q8 = scaled_delay();
    r.event_type = pr_run_type;
    r.channel = pr_run_chan;
    r.first_param = pr_first;
    r.second_param = second;
    r.last = 1'b1;
    pr_phase = PH_DELTA;
    pr_len_acc = '0;
    pr_len_cnt = '0;
    return r;
  endfunction

  function automatic result_t meta_result(input logic [2:0] k, input logic [27:0] len,
                                          input logic [7:0] d, input logic lst);
    result_t r;
    r = '0;
    r.kind = k;
    r.delay_us_q8 = scaled_delay();
    r.event_type = 4'hF;
    r.channel = pr_meta_chan;
    r.meta_type = pr_meta_type;
    r.meta_length = len;
    r.data_byte = d;
    r.last = lst;
    return r;
  endfunction

  // Program change and channel pressure carry a single data byte.
  function automatic bit single_data(input logic [3:0] t);
    return t == 4'hC || t == 4'hD;
  endfunction

  // Advances the local parser by one item and yields the result it causes, if any.
  function automatic void parse_track_byte(input logic f, input logic [7:0] b,
                                           output bit has, output result_t r);
    bit is_eot;
    has = 1'b0;
    r = '0;
    if (pr_ended) begin
      // Once the track has ended every item reports end of track.
      has = 1'b1;
      r.kind = mtep_pkg::KIND_EOT;
      r.last = 1'b1;
    end else if (f) begin
      // End of input drops the partial event and restarts at a delta time.
      has = 1'b1;
      r.kind = mtep_pkg::KIND_PREM;
      r.last = 1'b1;
      pr_phase = PH_DELTA;
      pr_len_acc = '0;
      pr_len_cnt = '0;
      pr_meta_left = '0;
    end else begin
      is_eot = pr_meta_type == META_EOT;
      case (pr_phase)
        PH_STATUS, PH_DATA1: begin
          if (pr_phase == PH_STATUS && b[7]) begin
            if (b[7:4] == 4'hF) begin
              // Meta events leave the running status alone.
              pr_meta_chan = b[3:0];
              pr_phase = PH_MTYPE;
            end else begin
              pr_run_type = b[7:4];
              pr_run_chan = b[3:0];
              pr_phase = PH_DATA1;
            end
          end else begin
            pr_first = b[6:0];
            if (single_data(pr_run_type)) begin
              has = 1'b1;
              r = channel_result(7'd0);
            end else begin
              pr_phase = PH_DATA2;
            end
          end
        end
        PH_DATA2: begin
          has = 1'b1;
          r = channel_result(b[6:0]);
        end
        PH_MTYPE: begin
          pr_meta_type = b;
          pr_len_acc = '0;
          pr_len_cnt = '0;
          pr_phase = PH_MLEN;
        end
        PH_MLEN: begin
          if (take_length_byte(b)) begin
            has = 1'b1;
            pr_meta_left = pr_len_acc;
            if (pr_len_acc == '0) begin
              r = meta_result(is_eot ? mtep_pkg::KIND_EOT : mtep_pkg::KIND_MHEAD,
                              '0, '0, 1'b1);
              if (is_eot) pr_ended = 1'b1;
              pr_phase = PH_DELTA;
              pr_len_acc = '0;
              pr_len_cnt = '0;
            end else begin
              r = meta_result(mtep_pkg::KIND_MHEAD, pr_len_acc, '0, 1'b0);
              pr_phase = PH_MDATA;
            end
          end
        end
        PH_MDATA: begin
          has = 1'b1;
          pr_meta_left = pr_meta_left - 28'd1;
          if (pr_meta_left == '0) begin
            // The final data byte of an end-of-track meta reports end of track.
            r = meta_result(is_eot ? mtep_pkg::KIND_EOT : mtep_pkg::KIND_MDATA,
                            pr_len_acc, b, 1'b1);
            if (is_eot) pr_ended = 1'b1;
            pr_phase = PH_DELTA;
            pr_len_acc = '0;
            pr_len_cnt = '0;
          end else begin
            r = meta_result(mtep_pkg::KIND_MDATA, pr_len_acc, b, 1'b0);
          end
        end
        default: begin
          if (take_length_byte(b)) begin
            pr_ticks = pr_len_acc;
            pr_len_acc = '0;
            pr_len_cnt = '0;
            pr_phase = PH_STATUS;
          end
        end
      endcase
    end
  endfunction

  function automatic string show(input result_t r);
    return $sformatf({"kind=%0d delay=%h type=%h chan=%h p1=%h p2=%h ",
                      "mtype=%h mlen=%h data=%h last=%b"},
                     r.kind, r.delay_us_q8, r.event_type, r.channel, r.first_param,
                     r.second_param, r.meta_type, r.meta_length, r.data_byte, r.last);
  endfunction

  // Sends one item, idling at random first, and records what it should cause.
  // When a kind is given, the prediction itself must agree with it.
  task automatic send_item(input logic f, input logic [7:0] b,
                           input bit typed = 1'b0,
                           input logic [2:0] k = mtep_pkg::KIND_CHAN);
    bit      has;
    result_t r;
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    track_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    parse_track_byte(f, b, has, r);
    if (typed && (!has || r.kind != k)) begin
      $display("%0t: directed item %0d expected kind %0d, predicted %0d (result %b)",
               $time, items_sent, k, r.kind, has);
      error_count++;
    end
    if (has) pending_results = {pending_results, r};
  endtask

  // Waits until the block owes nothing and has had time to finish its work.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mtep_pkg::CFG_TIMING_IS_FPS:     cur_fps_mode = val[0];
      mtep_pkg::CFG_FRAMES_PER_SECOND: cur_fps = val[6:0];
      mtep_pkg::CFG_FRAME_TICKS:       cur_tpf = val[7:0];
      mtep_pkg::CFG_BEAT_TICKS:        cur_tpb = val[14:0];
      mtep_pkg::CFG_TEMPO_US:          cur_mpb = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Writes all five registers. The first sets hit the extremes and the zero
  // divisors; later ones are random.
  task automatic load_config(input int set_no);
    logic [23:0] v [0:4];
    case (set_no)
      0: v = '{24'd1, 24'd127, 24'd255, 24'd32767, 24'hFFFFFF};
      1: v = '{24'd1, 24'd1, 24'd1, 24'd1, 24'd1};
      2: v = '{24'd0, 24'd127, 24'd255, 24'd1, 24'hFFFFFF};
      3: v = '{24'd0, 24'd1, 24'd1, 24'd32767, 24'd1};
      4: v = '{24'd1, 24'd0, 24'd0, 24'd0, 24'd0};
      5: v = '{24'd0, 24'd3, 24'd7, 24'd0, 24'd123};
      default: begin
        v[0] = 24'($urandom_range(1));
        v[1] = 24'($urandom_range(127, 1));
        v[2] = 24'($urandom_range(255, 1));
        v[3] = 24'($urandom_range(32767, 1));
        v[4] = 24'($urandom_range(24'hFFFFFF, 1));
      end
    endcase
    for (int i = 0; i < 5; i++) write_reg(3'(i), v[i]);
    config_sets++;
  endtask

  // Variable-length delta time of one to four bytes; the four-byte form sometimes
  // keeps the top bit set on its last byte.
  task automatic send_delta();
    int n;
    n = $urandom_range(3) == 0 ? $urandom_range(4, 2) : 1;
    for (int i = 0; i < n; i++) begin
      if (i < n - 1 || (n == MAX_LEN_BYTES && $urandom_range(1)))
        send_item(1'b0, 8'h80 | 8'($urandom_range(127)));
      else
        send_item(1'b0, 8'($urandom_range(127)));
    end
  endtask

  // Data byte of a channel event; now and then with the top bit set.
  function automatic logic [7:0] data_value();
    return $urandom_range(7) == 0 ? 8'($urandom_range(255, 128)) : 8'($urandom_range(127));
  endfunction

  // Meta event with a short length, optionally in a padded multi-byte form.
  task automatic send_meta(input logic [7:0] mtype, input int len);
    send_item(1'b0, 8'hF0 | 8'($urandom_range(15)));
    send_item(1'b0, mtype);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(3, 1)) send_item(1'b0, 8'h80);
    end
    send_item(1'b0, 8'(len));
    repeat (len) send_item(1'b0, 8'($urandom_range(255)));
  endtask

  // One random event: mostly well formed, sometimes cut short or noise.
  task automatic send_event(inout logic [3:0] gen_type);
    int          pick;
    logic [7:0]  st;
    logic [7:0]  mt;
    send_delta();
    pick = $urandom_range(19);
    if (pick < 5) begin
      // Running status: the first data byte stands where the status would.
      send_item(1'b0, 8'($urandom_range(127)));
      if (!single_data(gen_type)) send_item(1'b0, data_value());
    end else if (pick < 13) begin
      st = 8'($urandom_range(8'hEF, 8'h80));
      gen_type = st[7:4];
      send_item(1'b0, st);
      send_item(1'b0, data_value());
      if (!single_data(gen_type)) send_item(1'b0, data_value());
    end else if (pick < 17) begin
      mt = 8'($urandom_range(255));
      if (mt == META_EOT) mt = 8'h51;
      send_meta(mt, $urandom_range(5));
    end else if (pick < 19) begin
      // Broken event: a few raw bytes, then end of input to resynchronize.
      repeat ($urandom_range(3)) send_item(1'b0, 8'($urandom_range(255)));
      send_item(1'b1, 8'($urandom_range(255)));
    end else begin
      send_item(1'b1, 8'($urandom_range(255)));
    end
  endtask

  // Directed table: running status before any status, a top-bit data byte,
  // one-byte and two-byte events, an empty meta, meta data, a long delta
  // whose fourth byte keeps the top bit, and end of input.
  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{1'b0, 8'h00, 1'b0, mtep_pkg::KIND_CHAN}, '{1'b0, 8'h40, 1'b0, mtep_pkg::KIND_CHAN},
    '{1'b0, 8'h7F, 1'b1, mtep_pkg::KIND_CHAN},
    '{1'b0, 8'h81, 1'b0, mtep_pkg::KIND_CHAN}, '{1'b0, 8'h00, 1'b0, mtep_pkg::KIND_CHAN},
    '{1'b0, 8'h90, 1'b0, mtep_pkg::KIND_CHAN}, '{1'b0, 8'h3C, 1'b0, mtep_pkg::KIND_CHAN},
    '{1'b0, 8'hFF, 1'b1, mtep_pkg::KIND_CHAN},
    '{1'b0, 8'h00, 1'b0, mtep_pkg::KIND_CHAN}, '{1'b0, 8'hC5, 1'b0, mtep_pkg::KIND_CHAN},
    '{1'b0, 8'h10, 1'b1, mtep_pkg::KIND_CHAN},
    '{1'b0, 8'h00, 1'b0, mtep_pkg::KIND_CHAN}, '{1'b0, 8'hFF, 1'b0, mtep_pkg::KIND_CHAN},
    '{1'b0, 8'h03, 1'b0, mtep_pkg::KIND_CHAN}, '{1'b0, 8'h00, 1'b1, mtep_pkg::KIND_MHEAD},
    '{1'b0, 8'h00, 1'b0, mtep_pkg::KIND_CHAN}, '{1'b0, 8'hF7, 1'b0, mtep_pkg::KIND_CHAN},
    '{1'b0, 8'h01, 1'b0, mtep_pkg::KIND_CHAN}, '{1'b0, 8'h02, 1'b1, mtep_pkg::KIND_MHEAD},
    '{1'b0, 8'hAA, 1'b1, mtep_pkg::KIND_MDATA}, '{1'b0, 8'hBB, 1'b1, mtep_pkg::KIND_MDATA},
    '{1'b0, 8'hFF, 1'b0, mtep_pkg::KIND_CHAN}, '{1'b0, 8'hFF, 1'b0, mtep_pkg::KIND_CHAN},
    '{1'b0, 8'hFF, 1'b0, mtep_pkg::KIND_CHAN}, '{1'b0, 8'hFF, 1'b0, mtep_pkg::KIND_CHAN},
    '{1'b0, 8'hD2, 1'b0, mtep_pkg::KIND_CHAN}, '{1'b0, 8'h55, 1'b1, mtep_pkg::KIND_CHAN},
    '{1'b0, 8'h00, 1'b0, mtep_pkg::KIND_CHAN}, '{1'b0, 8'h90, 1'b0, mtep_pkg::KIND_CHAN},
    '{1'b1, 8'h5A, 1'b1, mtep_pkg::KIND_PREM}
  };

  // The receiver stalls at random, except during the calm stretch.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{kind, delay_us_q8, event_type, channel, first_param, second_param,
              meta_type, meta_length, data_byte, last};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: %s", $time, show(got));
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got !== want) begin
          $display("%0t: mismatch expected %s", $time, show(want));
          $display("%0t:          actual   %s", $time, show(got));
          error_count++;
        end
      end
    end
  end

  // The watchdog ends a run in which nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results still owed",
                 $time, STALL_LIMIT, pending_results.size());
        $display("midi_track_event_parser_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] gen_type;
    int         next_cfg;
    int         eot_len;
    rst = 1'b1;
    in_valid = 1'b0;
    func = 1'b0;
    track_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = mtep_pkg::CFG_TIMING_IS_FPS;
    cfg_data = 24'd0;
    out_stall = 1'b0;
    // The local copy starts from the documented reset values.
    cur_fps_mode = 1'b0;
    cur_fps = 7'd25;
    cur_tpf = 8'd40;
    cur_tpb = 15'd96;
    cur_mpb = 24'd500000;
    pr_phase = PH_DELTA;
    pr_len_acc = '0;
    pr_len_cnt = '0;
    pr_ticks = '0;
    pr_run_type = '0;
    pr_run_chan = '0;
    pr_first = '0;
    pr_meta_type = '0;
    pr_meta_left = '0;
    pr_ended = 1'b0;
    pr_meta_chan = '0;
    gen_type = 4'h0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part runs on the reset configuration.
    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_tab[i].f, dir_tab[i].b, dir_tab[i].typed, dir_tab[i].k);

    // Random part, switching configuration every few hundred items, with one
    // stretch of traffic that never idles.
    next_cfg = items_sent;
    while (items_sent < NUM_ITEMS) begin
      if (items_sent >= next_cfg) begin
        wait_drained();
        load_config(config_sets);
        next_cfg = items_sent + CFG_PERIOD;
      end
      calm = items_sent > 600 && items_sent < 850;
      send_event(gen_type);
    end
    calm = 1'b0;

    // End of track closes the run; every later item reports end of track.
    send_delta();
    eot_len = $urandom_range(2);
    send_meta(META_EOT, eot_len);
    repeat (6) send_item(1'($urandom_range(1)), 8'($urandom_range(255)));

    wait_drained();
    $display("Sent %0d items over %0d register sets, checked %0d results.",
             items_sent, config_sets, results_checked);
    if (error_count == 0) begin
      $display("midi_track_event_parser_unit test passed");
    end else begin
      $display("midi_track_event_parser_unit test failed");
    end
    $finish;
  end

endmodule
